### rtl/core/lzbr_pkg.sv
package lzbr_pkg;

  localparam int unsigned HistDepth  = 4096;
  localparam int unsigned HistAw     = 12;
  localparam int unsigned HeaderLast = 15;
  localparam int unsigned GroupBytes = 8;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FLAG   = 3'd1,
    PH_TOKEN  = 3'd2,
    PH_REF2   = 3'd3,
    PH_REF3   = 3'd4,
    PH_COPY   = 3'd5,
    PH_CLEAR  = 3'd6
  } phase_e;

endpackage

### rtl/core/lzbr_ram.sv
module lzbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/lz_backref_stream_decompressor_unit.sv
// LZ back-reference stream decompressor. Compressed bytes enter one per
// transfer on the slave side. A 16-byte header comes first, and its bytes 4 to 7
// give the decoded size, big-endian. Decoded bytes leave in groups of up to eight
// on the master side. tlast marks the last group produced by one literal or one
// back-reference, and tuser marks the last group of the stream. After reset a
// clearing pass zeroes all 4096 entries of the history memory, and no byte is
// accepted during it. Header, flag, literal and back-reference control bytes are
// parsed as they arrive. A back-reference of length L then holds the input while
// its L bytes are copied, one byte per cycle unless the stall below applies, through
// the registered read port of the 4096-byte history memory. Any cycle that completes
// a group waits while the output register still holds a group not yet accepted.
module lz_backref_stream_decompressor_unit
  import lzbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_byte0..out_byte7, byte_count, 4 zero bits
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser    // stream_done
);

  phase_e        ph_q, ph_d;
  logic [3:0]    hpos_q;
  logic [32:0]   rem_q;
  logic [7:0]    flag_q;
  logic [3:0]    fleft_q;
  logic [7:0]    tok1_q, tok2_q;
  logic [HistAw-1:0] wp_q, clr_q;
  logic [8:0]    len_q;     // bytes still to copy
  logic          rdv_q;     // read issued last cycle
  logic          copy_end_q;

  // group builder
  logic [7:0]    gb_q [GroupBytes];
  logic [3:0]    gcnt_q;
  logic [7:0]    ob_q [GroupBytes];
  logic [3:0]    ocnt_q;
  logic          ov_q, olast_q, odone_q;

  logic          in_fire, out_free;
  logic          we;
  logic [7:0]    wdata;
  logic [HistAw-1:0] raddr, waddr, back_dist;
  logic [7:0]    rdata;
  logic          emit, emit_last, emit_done;
  logic [7:0]    hist_byte;

  assign out_free = !ov_q || m_axis_tready;
  // in PH_REF2 the low distance byte is still on the input, so it is taken from there
  assign back_dist = {tok1_q[3:0], (ph_q == PH_REF2) ? s_axis_tdata : tok2_q}
                     + HistAw'(1);
  // a byte written last cycle may be the one read now: forward it
  logic          fwd_q;
  logic [7:0]    fwd_data_q;

  assign hist_byte = fwd_q ? fwd_data_q : rdata;

  // byte accept only in parse phases; a token byte only when a group can be flushed
  always_comb begin
    s_axis_tready = 1'b0;
    case (ph_q)
      PH_HEADER, PH_FLAG, PH_REF2, PH_REF3: s_axis_tready = 1'b1;
      PH_TOKEN: s_axis_tready = out_free;
      default:  s_axis_tready = 1'b0;
    endcase
  end
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // copy step: consume read data when the group can take it
  logic copy_step;
  assign copy_step = (ph_q == PH_COPY) && rdv_q &&
                     (out_free || (gcnt_q != 4'd7 && len_q != 9'd1));

  always_comb begin
    we = 1'b0; wdata = s_axis_tdata; waddr = wp_q;
    emit = 1'b0; emit_last = 1'b0; emit_done = 1'b0;
    if (ph_q == PH_CLEAR) begin
      we = 1'b1; wdata = 8'd0; waddr = clr_q;
    end else if (in_fire && ph_q == PH_TOKEN && flag_q[7]) begin
      we = 1'b1;
      emit = 1'b1; emit_last = 1'b1;
      emit_done = (rem_q <= 33'd1);
    end else if (copy_step) begin
      we = 1'b1; wdata = hist_byte;
      emit = 1'b1;
      emit_last = (len_q == 9'd1);
      emit_done = (len_q == 9'd1) && copy_end_q;
    end
  end

  // read address: next source byte
  assign raddr = (we ? wp_q + HistAw'(1) : wp_q) - back_dist;

  lzbr_ram #(.Width(8), .Depth(HistDepth)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control
  logic [8:0] ref_len;
  always_comb begin
    ph_d = ph_q;
    ref_len = '0;
    case (ph_q)
      PH_CLEAR: if (clr_q == HistAw'(HistDepth - 1)) ph_d = PH_HEADER;
      PH_HEADER: if (in_fire && hpos_q == 4'(HeaderLast))
        ph_d = (rem_q != 0) ? PH_FLAG : PH_HEADER;
      PH_FLAG:  if (in_fire) ph_d = PH_TOKEN;
      PH_TOKEN: if (in_fire) begin
        if (!flag_q[7]) ph_d = PH_REF2;
        else if (rem_q <= 33'd1) ph_d = PH_HEADER;
        else ph_d = (fleft_q > 4'd1) ? PH_TOKEN : PH_FLAG;
      end
      PH_REF2:  if (in_fire) ph_d = (tok1_q[7:4] == 4'd0) ? PH_REF3 : PH_COPY;
      PH_REF3:  if (in_fire) ph_d = PH_COPY;
      PH_COPY:  if (copy_step && len_q == 9'd1) begin
        if (copy_end_q) ph_d = PH_HEADER;
        else ph_d = (fleft_q > 4'd1) ? PH_TOKEN : PH_FLAG;
      end
      default: ph_d = PH_HEADER;
    endcase
    if (ph_q == PH_REF2) ref_len = {5'd0, tok1_q[7:4]} + 9'd2;
    else ref_len = {1'b0, s_axis_tdata} + 9'h12;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_CLEAR; hpos_q <= '0; rem_q <= '0; flag_q <= '0; fleft_q <= '0;
      tok1_q <= '0; tok2_q <= '0; wp_q <= '0; clr_q <= '0; len_q <= '0;
      rdv_q <= 1'b0; copy_end_q <= 1'b0; fwd_q <= 1'b0; fwd_data_q <= '0;
    end else begin
      ph_q <= ph_d;
      if (ph_q == PH_CLEAR) clr_q <= clr_q + HistAw'(1);
      if (we && ph_q != PH_CLEAR) wp_q <= wp_q + HistAw'(1);
      // forward when the next read hits the entry just written
      fwd_q <= we && ph_q != PH_CLEAR && raddr == wp_q;
      fwd_data_q <= wdata;
      rdv_q <= (ph_d == PH_COPY);
      if (in_fire) begin
        case (ph_q)
          PH_HEADER: begin
            if (hpos_q == 4'd0) rem_q <= '0;
            if (hpos_q >= 4'd4 && hpos_q < 4'd8)
              rem_q <= {1'b0, rem_q[23:0], s_axis_tdata};
            hpos_q <= hpos_q + 4'd1;
            if (hpos_q == 4'(HeaderLast)) begin
              flag_q <= '0; fleft_q <= '0;
            end
          end
          PH_FLAG: begin
            flag_q <= s_axis_tdata; fleft_q <= 4'd8;
          end
          PH_TOKEN: begin
            if (!flag_q[7]) tok1_q <= s_axis_tdata;
            else begin
              if (rem_q != 0) rem_q <= rem_q - 33'd1;
              if (rem_q <= 33'd1) begin
                flag_q <= '0; fleft_q <= '0;
              end else begin
                flag_q <= {flag_q[6:0], 1'b0}; fleft_q <= fleft_q - 4'd1;
              end
            end
          end
          PH_REF2, PH_REF3: begin
            if (ph_q == PH_REF2) tok2_q <= s_axis_tdata;
            if (ph_d == PH_COPY) begin
              len_q <= ref_len;
              copy_end_q <= {24'd0, ref_len} >= rem_q;
              if ({24'd0, ref_len} >= rem_q) rem_q <= '0;
              else rem_q <= rem_q - {24'd0, ref_len};
            end
          end
          default: ;
        endcase
      end
      if (copy_step) begin
        len_q <= len_q - 9'd1;
        if (len_q == 9'd1) begin
          if (copy_end_q) begin
            flag_q <= '0; fleft_q <= '0;
          end else begin
            flag_q <= {flag_q[6:0], 1'b0}; fleft_q <= fleft_q - 4'd1;
          end
        end
      end
    end
  end

  // group assembly and output register
  logic flush;
  assign flush = emit && (emit_last || gcnt_q == 4'd7);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcnt_q <= '0; ov_q <= 1'b0; ocnt_q <= '0; olast_q <= 1'b0; odone_q <= 1'b0;
    end else begin
      if (flush) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (emit) begin
        if (flush) begin
          ocnt_q <= gcnt_q + 4'd1;
          olast_q <= emit_last;
          odone_q <= emit_done;
          gcnt_q <= '0;
        end else begin
          gcnt_q <= gcnt_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (flush) begin
        for (int i = 0; i < GroupBytes; i++) begin
          ob_q[i] <= (4'(i) < gcnt_q) ? gb_q[i] : ((4'(i) == gcnt_q) ? wdata : 8'd0);
        end
      end else begin
        gb_q[gcnt_q[2:0]] <= wdata;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = odone_q;
  assign m_axis_tdata  = {4'd0, ocnt_q, ob_q[7], ob_q[6], ob_q[5], ob_q[4],
                          ob_q[3], ob_q[2], ob_q[1], ob_q[0]};

  // a flush never lands on a held group
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |-> out_free) else $error("output group overwritten");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ocnt_q != 4'd0 && ocnt_q <= 4'd8)) else $error("bad byte count");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && odone_q) |-> olast_q) else $error("done without last");
  a_copy_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_COPY) |-> !s_axis_tready) else $error("input during copy");

endmodule
